/* sv/dpq_pkg.sv */
// dpq_pkg: shared constants of the double-ended priority queue
// operation codes, status codes and default sizes; no dependencies
package dpq_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // operation codes
    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_POP_MAX = 3'd1;
    localparam logic [2:0] MODE_POP_MIN = 3'd2;
    localparam logic [2:0] MODE_REPORT  = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

/* sv/dpq_mem.sv */
// dpq_mem: value store, one write port and one registered read port
// depends on nothing; sized by its parameters
module dpq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/double_ended_priority_queue.sv */
// double_ended_priority_queue: top level, control around the sorted value store
// depends on dpq_pkg and dpq_mem
//
// channel   direction  handshake            payload
// command   in         start & !busy        mode, value
// result    out        strobe (one cycle)   status, largest, smallest, count
//
// values sit sorted in a circular buffer in dpq_mem; extremes are kept in registers
// insert at either end, clear, report and removal from a store of one: done in S_IDLE
// removal otherwise: S_IDLE issues one memory read for the new extreme, S_FMAX or S_FMIN takes it
// insert in the middle: S_IDLE reads the top value, then S_SHIFT moves each held value above it up one slot
// (one read and one shifting write per cycle through the memory port pair)
// reset clears the count and the control state; the store needs no clearing
// the result receiver cannot stall; a result appears the cycle after completion
module double_ended_priority_queue
    import dpq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   mode,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         strobe,
    output logic [1:0]                   status,
    output logic signed [VALUE_BITS-1:0] largest,
    output logic signed [VALUE_BITS-1:0] smallest,
    output logic [CW-1:0]                count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_FMAX  = 4'b0100,
        S_FMIN  = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic signed [VALUE_BITS-1:0]  max_reg, max_next;
    logic signed [VALUE_BITS-1:0]  min_reg, min_next;
    logic signed [VALUE_BITS-1:0]  key_reg, key_next;
    logic [1:0]                    status_next;
    logic                          done;

    logic                          strobe_reg;
    logic [1:0]                    status_reg;
    logic signed [VALUE_BITS-1:0]  largest_reg, smallest_reg;
    logic [CW-1:0]                 count_out_reg;

    logic                          wr_en, rd_en;
    logic [AW-1:0]                 wr_addr, rd_addr;
    logic signed [VALUE_BITS-1:0]  wr_data, rd_data;

    // physical slot of a sorted position, one wrap correction
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    dpq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // operation sequencing; the shift reads pos-1 while writing pos+1, so no overlap
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        key_next    = key_reg;
        status_next = ST_DONE;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = key_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                done        = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = head_reg;
                                wr_data    = value;
                                max_next   = value;
                                min_next   = value;
                                count_next = CW'(1);
                                done       = 1'b1;
                            end
                            else if (value >= max_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = slot(head_reg, count_reg);
                                wr_data    = value;
                                max_next   = value;
                                count_next = count_reg + CW'(1);
                                done       = 1'b1;
                            end
                            else if (value < min_reg)
                            begin
                                head_next  = (head_reg == '0) ? AW'(CAPACITY - 1)
                                                              : head_reg - AW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = head_next;
                                wr_data    = value;
                                min_next   = value;
                                count_next = count_reg + CW'(1);
                                done       = 1'b1;
                            end
                            else
                            begin
                                key_next   = value;
                                pos_next   = count_reg - CW'(1);
                                rd_en      = 1'b1;
                                rd_addr    = slot(head_reg, count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_POP_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done        = 1'b1;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next = '0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                rd_en      = 1'b1;
                                rd_addr    = slot(head_reg, count_reg - CW'(2));
                                state_next = S_FMAX;
                            end
                        end
                        MODE_POP_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                done        = 1'b1;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next = '0;
                                done       = 1'b1;
                            end
                            else
                            begin
                                head_next  = slot(head_reg, CW'(1));
                                count_next = count_reg - CW'(1);
                                rd_en      = 1'b1;
                                rd_addr    = head_next;
                                state_next = S_FMIN;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            status_next = (count_reg == '0) ? ST_EMPTY : ST_DONE;
                            done        = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, pos_reg + CW'(1));
                if (rd_data > key_reg)
                begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - CW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = slot(head_reg, pos_reg - CW'(1));
                end
                else
                begin
                    wr_data    = key_reg;
                    count_next = count_reg + CW'(1);
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FMAX:
            begin
                max_next   = rd_data;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_FMIN:
            begin
                min_next   = rd_data;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            strobe_reg <= done;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        max_reg <= max_next;
        min_reg <= min_next;
        key_reg <= key_next;
        if (done)
        begin
            status_reg    <= status_next;
            count_out_reg <= count_next;
            largest_reg   <= (count_next == '0) ? '0 : max_next;
            smallest_reg  <= (count_next == '0) ? '0 : min_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign largest  = largest_reg;
    assign smallest = smallest_reg;
    assign count    = count_out_reg;

endmodule

/* sv/dpq_checker.sv */
// dpq_checker: port-level assertions on the priority queue, with its bind
// depends on dpq_pkg and double_ended_priority_queue
module dpq_checker
    import dpq_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [2:0]                   mode,
    input logic signed [VALUE_BITS-1:0] value,
    input logic                         strobe,
    input logic [1:0]                   status,
    input logic signed [VALUE_BITS-1:0] largest,
    input logic signed [VALUE_BITS-1:0] smallest,
    input logic [CW-1:0]                count
);

    // count never beyond capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (count <= CW'(CAPACITY)))
        else $error("count beyond capacity");

    // an empty store shows zero extremes
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && count == '0) |-> (largest == '0 && smallest == '0))
        else $error("extremes not zero on empty store");

    // a dropped insert only on a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == ST_FULL) |-> (count == CW'(CAPACITY)))
        else $error("full status below capacity");

    // extremes ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && count != '0) |-> (largest >= smallest))
        else $error("largest below smallest");

    // clear answers in the next cycle with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_CLEAR) |=> (strobe && count == '0))
        else $error("clear transfer not answered");

endmodule

bind double_ended_priority_queue dpq_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .CW         (CW)
) u_dpq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .largest  (largest),
    .smallest (smallest),
    .count    (count)
);
